// ----- rtl/pbc_pkg.sv -----
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared codes and controller/datapath handshake types for the block cache.
// ----------------------------------------------------------------------------
`default_nettype none
package pbc_pkg;

  localparam logic [2:0] FUNC_LOOKUP  = 3'd0;
  localparam logic [2:0] FUNC_PUBLISH = 3'd1;
  localparam logic [2:0] FUNC_MARK    = 3'd2;
  localparam logic [2:0] FUNC_EVICT   = 3'd3;
  localparam logic [2:0] FUNC_QUERY   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_SKIPPED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NONE_IDLE = 3'd4;
  localparam logic [2:0] ST_NOT_CACHE = 3'd5;
  localparam logic [2:0] ST_ALR_IDLE  = 3'd6;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 192;

  typedef struct packed {
    logic load;
    logic match;
    logic sel;
    logic grp;
    logic upd;
  } pbc_cmd_t;

  typedef struct packed {
    logic is_evict;
  } pbc_sts_t;

endpackage
`default_nettype wire

// ----- rtl/prefix_block_cache_table_top.sv -----
// ----------------------------------------------------------------------------
// prefix_block_cache_table_top
// Hash-keyed block cache with an idle LRU list, stream in and stream out.
// ----------------------------------------------------------------------------
// sequence: after the accepting edge the compare, select and update steps
//   follow, evict adding a group compare pass; m_tvalid is registered by
//   the update, which waits while the previous result is still held on m_tready
// acceptance: a new transaction is taken only after the previous update;
//   set by the sequencer walking the shared compare lanes step by step
// reset: synchronous; clears entry valid and idle bits, counters and skip
//   flag at once, no clearing pass
`default_nettype none
module prefix_block_cache_table_top
  import pbc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // block_hash[63:0], block_num[79:64], prefix_start[80], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // func[2:0]
  input  wire logic [2:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // block_out[15:0], hash_out[79:16], is_cached[80], is_idle_flag[81],
  // cached_count[88:82], idle_count[95:89], hit_total[127:96],
  // miss_total[159:128], eviction_total[191:160]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // status[2:0]
  output logic [2:0]                 m_tuser
);

  pbc_cmd_t cmd;
  pbc_sts_t sts;

  pbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pbc_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_func    (s_tuser),
    .in_data    (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (m_tuser),
    .res_data   (m_tdata)
  );

endmodule
`default_nettype wire

// ----- rtl/pbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer: steps each transaction through match, select, group (evict only)
// and update, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module pbc_ctrl
  import pbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output pbc_cmd_t      cmd,
  input  wire pbc_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_GRP   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = sts.is_evict ? S_GRP : S_UPD;
      end
      S_GRP: begin
        cmd.grp    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.upd) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_upd_free: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> (!out_valid || m_tready))
    else $error("update while output still held");
  a_rise_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.upd))
    else $error("output valid without update");
  a_cmd_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.match, cmd.sel, cmd.grp, cmd.upd}))
    else $error("more than one command");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !s_tready)
    else $error("accepted a transaction while busy");

endmodule
`default_nettype wire

// ----- rtl/pbc_datapath.sv -----
// ----------------------------------------------------------------------------
// pbc_datapath
// Entry table with per-entry compare lanes, first-match select, group and
// idle rank maintenance, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pbc_datapath
  import pbc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [2:0]            in_func,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire pbc_cmd_t              cmd,
  output pbc_sts_t                   sts,
  output logic [2:0]                 res_status,
  output logic [OUT_DATA_W-1:0]      res_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic              ent_valid [ENTRIES];
  logic [63:0]       ent_hash  [ENTRIES];
  logic [15:0]       ent_block [ENTRIES];
  logic [IW-1:0]     ent_gpos  [ENTRIES];
  logic              ent_idle  [ENTRIES];
  logic [IW-1:0]     ent_rank  [ENTRIES];

  logic [2:0]        op_func;
  logic [63:0]       op_hash;
  logic [15:0]       op_id;
  logic              op_pstart;

  logic [ENTRIES-1:0] cand_vec, free_vec, heq_vec, grp_vec;
  logic [ENTRIES-1:0] cand_c, free_c, heq_c, grp_c;
  logic [IW-1:0]     sel_idx, free_idx;
  logic              sel_found, free_found;
  logic [CW-1:0]     grp_size, grp_n;

  logic              prefix_skip;
  logic [31:0]       hits, misses, evictions;
  logic [CW-1:0]     cached_cnt, idle_cnt;

  function automatic logic [IW:0] first_set(input logic [ENTRIES-1:0] v);
    logic [IW:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, IW'(i)};
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] pop(input logic [ENTRIES-1:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int i = 0; i < ENTRIES; i++) r = r + CW'(v[i]);
    return r;
  endfunction

  function automatic logic [6:0] to7(input logic [CW-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[6:0];
  endfunction

  assign sts.is_evict = (op_func == FUNC_EVICT);

  // compare lanes, one per entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      heq_c[i]  = ent_valid[i] && (ent_hash[i] == op_hash);
      free_c[i] = !ent_valid[i];
      grp_c[i]  = ent_valid[i] && (ent_hash[i] == ent_hash[sel_idx]);
      case (op_func)
        FUNC_LOOKUP: cand_c[i] = heq_c[i] && (ent_gpos[i] == '0);
        FUNC_EVICT:  cand_c[i] = ent_valid[i] && ent_idle[i] && (ent_rank[i] == '0);
        default:     cand_c[i] = ent_valid[i] && (ent_block[i] == op_id);
      endcase
    end
  end

  // update-step decode
  logic          skip_eff, leave, regroup, do_write, do_mark, do_erase;
  logic [IW-1:0] r_rank, p_pos, last_pos;
  logic [2:0]    st;
  logic [15:0]   bout;
  logic [63:0]   hout;
  logic          cachedf, idlef;
  logic          skip_next;
  logic [31:0]   hits_next, misses_next, ev_next;
  logic [CW-1:0] cached_next, idle_next;

  always_comb begin
    skip_eff    = op_pstart ? 1'b0 : prefix_skip;
    leave       = 1'b0;
    regroup     = 1'b0;
    do_write    = 1'b0;
    do_mark     = 1'b0;
    do_erase    = 1'b0;
    r_rank      = ent_rank[sel_idx];
    p_pos       = ent_gpos[sel_idx];
    last_pos    = IW'(grp_n - CW'(1));
    st          = ST_OK;
    bout        = '0;
    hout        = '0;
    cachedf     = 1'b0;
    idlef       = 1'b0;
    skip_next   = prefix_skip;
    hits_next   = hits;
    misses_next = misses;
    ev_next     = evictions;
    cached_next = cached_cnt;
    idle_next   = idle_cnt;
    case (op_func)
      FUNC_LOOKUP: begin
        skip_next = skip_eff;
        if (skip_eff) begin
          st = ST_SKIPPED;
        end else if (!sel_found) begin
          st          = ST_MISS;
          misses_next = misses + 32'd1;
          skip_next   = 1'b1;
        end else begin
          if (ent_idle[sel_idx]) begin
            leave     = 1'b1;
            idle_next = idle_cnt - CW'(1);
          end
          hits_next = hits + 32'd1;
          bout      = ent_block[sel_idx];
          hout      = ent_hash[sel_idx];
        end
      end
      FUNC_PUBLISH: begin
        if (sel_found) begin
          hout = ent_hash[sel_idx];
        end else if (!free_found) begin
          st = ST_FULL;
        end else begin
          do_write    = 1'b1;
          cached_next = cached_cnt + CW'(1);
          hout        = op_hash;
        end
      end
      FUNC_MARK: begin
        if (!sel_found) begin
          st = ST_NOT_CACHE;
        end else if (ent_idle[sel_idx]) begin
          st = ST_ALR_IDLE;
        end else begin
          do_mark   = 1'b1;
          idle_next = idle_cnt + CW'(1);
        end
      end
      FUNC_EVICT: begin
        if (!sel_found) begin
          st = ST_NONE_IDLE;
        end else begin
          leave       = 1'b1;
          regroup     = 1'b1;
          do_erase    = 1'b1;
          bout        = ent_block[sel_idx];
          hout        = ent_hash[sel_idx];
          cached_next = cached_cnt - CW'(1);
          idle_next   = idle_cnt - CW'(1);
          ev_next     = evictions + 32'd1;
        end
      end
      FUNC_QUERY: begin
        if (!sel_found) begin
          st = ST_NOT_CACHE;
        end else begin
          cachedf = 1'b1;
          idlef   = ent_idle[sel_idx];
          hout    = ent_hash[sel_idx];
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        ent_valid[i] <= 1'b0;
        ent_idle[i]  <= 1'b0;
      end
      prefix_skip <= 1'b0;
      hits        <= '0;
      misses      <= '0;
      evictions   <= '0;
      cached_cnt  <= '0;
      idle_cnt    <= '0;
    end else begin
      if (cmd.load) begin
        op_func   <= in_func;
        op_hash   <= in_data[63:0];
        op_id     <= in_data[79:64];
        op_pstart <= in_data[80];
      end
      if (cmd.match) begin
        cand_vec <= cand_c;
        free_vec <= free_c;
        heq_vec  <= heq_c;
      end
      if (cmd.sel) begin
        {sel_found, sel_idx}   <= first_set(cand_vec);
        {free_found, free_idx} <= first_set(free_vec);
        grp_size               <= pop(heq_vec);
      end
      if (cmd.grp) begin
        grp_vec <= grp_c;
        grp_n   <= pop(grp_c);
      end
      if (cmd.upd) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (leave && ent_valid[i] && ent_idle[i] && (ent_rank[i] > r_rank)) begin
            ent_rank[i] <= ent_rank[i] - IW'(1);
          end
          // last member of the group fills the freed position
          if (regroup && (IW'(i) != sel_idx) && grp_vec[i] && (ent_gpos[i] == last_pos)) begin
            ent_gpos[i] <= p_pos;
          end
        end
        if (leave) ent_idle[sel_idx] <= 1'b0;
        if (do_erase) ent_valid[sel_idx] <= 1'b0;
        if (do_mark) begin
          ent_idle[sel_idx] <= 1'b1;
          ent_rank[sel_idx] <= IW'(idle_cnt);
        end
        if (do_write) begin
          ent_valid[free_idx] <= 1'b1;
          ent_hash[free_idx]  <= op_hash;
          ent_block[free_idx] <= op_id;
          ent_gpos[free_idx]  <= IW'(grp_size);
          ent_idle[free_idx]  <= 1'b0;
          ent_rank[free_idx]  <= '0;
        end
        prefix_skip <= skip_next;
        hits        <= hits_next;
        misses      <= misses_next;
        evictions   <= ev_next;
        cached_cnt  <= cached_next;
        idle_cnt    <= idle_next;
        res_status  <= st;
        res_data    <= {ev_next, misses_next, hits_next, to7(idle_next), to7(cached_next),
                        idlef, cachedf, hout, bout};
      end
    end
  end

  a_idle_le_cached: assert property (@(posedge clk) disable iff (rst)
    idle_cnt <= cached_cnt)
    else $error("idle count above cached count");
  a_cached_max: assert property (@(posedge clk) disable iff (rst)
    cached_cnt <= CW'(ENTRIES))
    else $error("cached count above table size");
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && do_write) |-> !ent_valid[free_idx])
    else $error("publish over a valid entry");

endmodule
`default_nettype wire
